// ===== hdl/fmt_pkg.sv =====
// ---------------------------------------------------------------------------
// fmt_pkg: shared definitions for the FM chip dual timer block
// Command codes, register addresses, timer constants, state types and the
// control and status bundles passed between the top level and the timer unit.
// ---------------------------------------------------------------------------
package fmt_pkg;

    // Command codes carried in the input item's tuser
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_ADV   = 2'd2;
    localparam logic [1:0] CMD_LATCH = 2'd3;

    // Register addresses
    localparam logic [7:0] ADDR_TA_HI = 8'h10;
    localparam logic [7:0] ADDR_TA_LO = 8'h11;
    localparam logic [7:0] ADDR_TB    = 8'h12;
    localparam logic [7:0] ADDR_CTRL  = 8'h14;

    // Port bit that selects the sound latch
    localparam int unsigned PORT_LATCH_BIT = 6;

    localparam logic [9:0] MAX_ADVANCE = 10'd512;

    localparam int unsigned CNT_A_W = 18;
    localparam int unsigned CNT_B_W = 20;
    localparam int unsigned ALU_W   = 21;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_ADV,
        TOP_OUT
    } fmt_top_state_t;

    typedef enum logic [2:0] {
        ADV_IDLE,
        ADV_SUB_A,
        ADV_FIX_A,
        ADV_SUB_B,
        ADV_FIX_B,
        ADV_DONE
    } fmt_adv_state_t;

    typedef struct packed {
        logic start;
        logic load_a;
        logic load_b;
    } fmt_adv_ctrl_t;

    typedef struct packed {
        logic done;
        logic ovf_a;
        logic ovf_b;
    } fmt_adv_stat_t;

endpackage

// ===== hdl/fmt_advance.sv =====
// ---------------------------------------------------------------------------
// fmt_advance: timer counters with one shared add/subtract unit
// Holds both down counters. An advance subtracts the clock count from each
// running timer and then adds the period back, one reload per cycle, until
// the count is positive again. Every step goes through the same adder.
// ---------------------------------------------------------------------------
module fmt_advance (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fmt_pkg::fmt_adv_ctrl_t ctrl,
    input  logic [9:0]            cyc,
    input  logic [1:0]            run,
    input  logic [9:0]            ta_val,
    input  logic [7:0]            tb_val,
    output fmt_pkg::fmt_adv_stat_t stat
);

    fmt_pkg::fmt_adv_state_t state_reg, state_next;

    logic signed [fmt_pkg::CNT_A_W-1:0] count_a_reg, count_a_next;
    logic signed [fmt_pkg::CNT_B_W-1:0] count_b_reg, count_b_next;

    logic [16:0] period_a;
    logic [18:0] period_b;

    logic signed [fmt_pkg::ALU_W-1:0] op_x, op_y, alu_sum;
    logic                             op_sub;

    logic a_le0, b_le0;

    assign period_a = {11'(11'd1024 - {1'b0, ta_val}), 6'b0};
    assign period_b = {9'(9'd256 - {1'b0, tb_val}), 10'b0};

    assign a_le0 = count_a_reg[fmt_pkg::CNT_A_W-1] || (count_a_reg == '0);
    assign b_le0 = count_b_reg[fmt_pkg::CNT_B_W-1] || (count_b_reg == '0);

    // The shared adder.
    assign alu_sum = op_sub ? (op_x - op_y) : (op_x + op_y);

    always_comb begin
        op_x   = '0;
        op_y   = '0;
        op_sub = 1'b0;
        case (state_reg)
            fmt_pkg::ADV_SUB_A, fmt_pkg::ADV_FIX_A: begin
                op_x = {{(fmt_pkg::ALU_W - fmt_pkg::CNT_A_W){count_a_reg[fmt_pkg::CNT_A_W-1]}},
                        count_a_reg};
            end
            fmt_pkg::ADV_SUB_B, fmt_pkg::ADV_FIX_B: begin
                op_x = {{(fmt_pkg::ALU_W - fmt_pkg::CNT_B_W){count_b_reg[fmt_pkg::CNT_B_W-1]}},
                        count_b_reg};
            end
            default: op_x = '0;
        endcase
        case (state_reg)
            fmt_pkg::ADV_SUB_A, fmt_pkg::ADV_SUB_B: begin
                op_y   = {11'b0, cyc};
                op_sub = 1'b1;
            end
            fmt_pkg::ADV_FIX_A: op_y = {4'b0, period_a};
            fmt_pkg::ADV_FIX_B: op_y = {2'b0, period_b};
            default:            op_y = '0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fmt_pkg::ADV_IDLE:  if (ctrl.start) state_next = fmt_pkg::ADV_SUB_A;
            fmt_pkg::ADV_SUB_A:
                state_next = run[0] ? fmt_pkg::ADV_FIX_A : fmt_pkg::ADV_SUB_B;
            fmt_pkg::ADV_FIX_A: if (!a_le0) state_next = fmt_pkg::ADV_SUB_B;
            fmt_pkg::ADV_SUB_B:
                state_next = run[1] ? fmt_pkg::ADV_FIX_B : fmt_pkg::ADV_DONE;
            fmt_pkg::ADV_FIX_B: if (!b_le0) state_next = fmt_pkg::ADV_DONE;
            fmt_pkg::ADV_DONE:  state_next = fmt_pkg::ADV_IDLE;
            default:            state_next = fmt_pkg::ADV_IDLE;
        endcase
    end

    always_comb begin
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        stat         = '0;
        case (state_reg)
            fmt_pkg::ADV_IDLE: begin
                if (ctrl.load_a) count_a_next = fmt_pkg::CNT_A_W'(period_a);
                if (ctrl.load_b) count_b_next = fmt_pkg::CNT_B_W'(period_b);
            end
            fmt_pkg::ADV_SUB_A: if (run[0]) count_a_next = alu_sum[fmt_pkg::CNT_A_W-1:0];
            fmt_pkg::ADV_FIX_A: begin
                if (a_le0) begin
                    count_a_next = alu_sum[fmt_pkg::CNT_A_W-1:0];
                    stat.ovf_a   = 1'b1;
                end
            end
            fmt_pkg::ADV_SUB_B: if (run[1]) count_b_next = alu_sum[fmt_pkg::CNT_B_W-1:0];
            fmt_pkg::ADV_FIX_B: begin
                if (b_le0) begin
                    count_b_next = alu_sum[fmt_pkg::CNT_B_W-1:0];
                    stat.ovf_b   = 1'b1;
                end
            end
            fmt_pkg::ADV_DONE: stat.done = 1'b1;
            default:           stat = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fmt_pkg::ADV_IDLE;
            count_a_reg <= '0;
            count_b_reg <= '0;
        end else begin
            state_reg   <= state_next;
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
        end
    end

endmodule

// ===== hdl/fm_chip_dual_timer_irq.sv =====
// ---------------------------------------------------------------------------
// fm_chip_dual_timer_irq: timer A/B and IRQ logic of an FM sound chip
//
//   Channel  Dir  tdata (low bit first)                      tuser
//   s_       in   port[7:0] wdata[15:8] cycles[25:16] pad    cmd[1:0]
//   m_       out  read_data[7:0] irq[8] pad                  -
//
// Port writes, reads and latch loads go straight from the accept to the result
// on m_. An advance runs the subtract and reload states of timer A, then of
// timer B, through the shared adder (timer A may need up to eight reloads).
// s_tready is high only while no item is in work; the result is held until
// taken. Reset is synchronous and clears all state.
// ---------------------------------------------------------------------------
module fm_chip_dual_timer_irq (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // port[7:0], wdata[15:8], cycles[25:16]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // read_data[7:0], irq[8]
);

    fmt_pkg::fmt_top_state_t state_reg, state_next;

    logic [7:0] addr_reg,  addr_next;
    logic [9:0] ta_reg,    ta_next;
    logic [7:0] tb_reg,    tb_next;
    logic [1:0] en_reg,    en_next;
    logic [1:0] run_reg,   run_next;
    logic [1:0] flags_reg, flags_next;
    logic [7:0] latch_reg, latch_next;
    logic       irq_reg,   irq_next;
    logic [7:0] rd_reg,    rd_next;
    logic [9:0] cyc_reg,   cyc_next;

    logic       accept;
    logic [1:0] cmd;
    logic [7:0] port;
    logic [7:0] wdata;
    logic [9:0] cycles;
    logic       data_wr;

    fmt_pkg::fmt_adv_ctrl_t adv_ctrl;
    fmt_pkg::fmt_adv_stat_t adv_stat;

    assign cmd    = s_tuser;
    assign port   = s_tdata[7:0];
    assign wdata  = s_tdata[15:8];
    assign cycles = s_tdata[25:16];
    assign accept = s_tvalid && s_tready;

    assign data_wr = accept && (cmd == fmt_pkg::CMD_WRITE)
                     && !port[fmt_pkg::PORT_LATCH_BIT] && port[0];

    fmt_advance u_adv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (adv_ctrl),
        .cyc     (cyc_reg),
        .run     (run_reg),
        .ta_val  (ta_reg),
        .tb_val  (tb_reg),
        .stat    (adv_stat)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fmt_pkg::TOP_IDLE: begin
                if (accept)
                    state_next = (cmd == fmt_pkg::CMD_ADV) ? fmt_pkg::TOP_ADV
                                                           : fmt_pkg::TOP_OUT;
            end
            fmt_pkg::TOP_ADV: if (adv_stat.done) state_next = fmt_pkg::TOP_OUT;
            fmt_pkg::TOP_OUT: if (m_tready) state_next = fmt_pkg::TOP_IDLE;
            default:          state_next = fmt_pkg::TOP_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == fmt_pkg::TOP_IDLE);
        m_tvalid = (state_reg == fmt_pkg::TOP_OUT);
        m_tdata  = {7'b0, irq_reg, rd_reg};
    end

    always_comb begin
        addr_next  = addr_reg;
        ta_next    = ta_reg;
        tb_next    = tb_reg;
        en_next    = en_reg;
        run_next   = run_reg;
        flags_next = flags_reg | {adv_stat.ovf_b, adv_stat.ovf_a};
        latch_next = latch_reg;
        irq_next   = irq_reg;
        rd_next    = rd_reg;
        cyc_next   = cyc_reg;
        adv_ctrl   = '0;

        if (accept) begin
            rd_next = '0;
            case (cmd)
                fmt_pkg::CMD_WRITE: begin
                    if (!port[fmt_pkg::PORT_LATCH_BIT] && !port[0]) addr_next = wdata;
                end
                fmt_pkg::CMD_READ: begin
                    rd_next = port[fmt_pkg::PORT_LATCH_BIT] ? latch_reg : {6'b0, flags_reg};
                end
                fmt_pkg::CMD_ADV: begin
                    cyc_next       = (cycles > fmt_pkg::MAX_ADVANCE) ? fmt_pkg::MAX_ADVANCE
                                                                     : cycles;
                    adv_ctrl.start = 1'b1;
                end
                default: latch_next = wdata;
            endcase
        end

        if (data_wr) begin
            case (addr_reg)
                fmt_pkg::ADDR_TA_HI: ta_next = {wdata, ta_reg[1:0]};
                fmt_pkg::ADDR_TA_LO: ta_next = {ta_reg[9:2], wdata[1:0]};
                fmt_pkg::ADDR_TB:    tb_next = wdata;
                fmt_pkg::ADDR_CTRL: begin
                    en_next         = wdata[3:2];
                    run_next        = wdata[1:0];
                    // A timer is reloaded only when it goes from stopped to running.
                    adv_ctrl.load_a = wdata[0] && !run_reg[0];
                    adv_ctrl.load_b = wdata[1] && !run_reg[1];
                    if (wdata[4]) flags_next[0] = 1'b0;
                    if (wdata[5]) flags_next[1] = 1'b0;
                end
                default: ta_next = ta_reg;
            endcase
        end

        if ((data_wr && (addr_reg == fmt_pkg::ADDR_CTRL)) || adv_stat.done)
            irq_next = |(flags_next & en_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fmt_pkg::TOP_IDLE;
            addr_reg  <= '0;
            ta_reg    <= '0;
            tb_reg    <= '0;
            en_reg    <= '0;
            run_reg   <= '0;
            flags_reg <= '0;
            latch_reg <= '0;
            irq_reg   <= 1'b0;
            rd_reg    <= '0;
            cyc_reg   <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            ta_reg    <= ta_next;
            tb_reg    <= tb_next;
            en_reg    <= en_next;
            run_reg   <= run_next;
            flags_reg <= flags_next;
            latch_reg <= latch_next;
            irq_reg   <= irq_next;
            rd_reg    <= rd_next;
            cyc_reg   <= cyc_next;
        end
    end

endmodule

// ===== hdl/fmt_checker.sv =====
// ---------------------------------------------------------------------------
// fmt_checker: port-level checks for the FM chip dual timer block
// Watches the stream ports only and is attached to the top level by bind.
// ---------------------------------------------------------------------------
module fmt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A waiting result keeps its value until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The block never takes an item while a result is still offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // After an item is taken, no second one is taken in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted during work");

    // A port write produces a zero read byte in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == fmt_pkg::CMD_WRITE)
        |=> m_tvalid && (m_tdata[7:0] == 8'h00))
        else $error("port write returned nonzero data");

    // Loading the sound latch leaves the IRQ line alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == fmt_pkg::CMD_LATCH)
        |=> $stable(m_tdata[8]))
        else $error("latch load changed the IRQ line");

endmodule

bind fm_chip_dual_timer_irq fmt_checker u_fmt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking bench for the FM chip dual timer and IRQ block
// A table of directed items covers reset values, the latch and status reads,
// ignored writes, capped and zero advances and repeated underflows. Random
// programming sequences, advance bursts and noise follow. Every result is
// checked against a fixed table value or the bench's behavioral timer model.
// ---------------------------------------------------------------------------
module tb;
    import fmt_pkg::*;

    // Register address with no function, used to check that data is dropped
    localparam logic [7:0] ADDR_SPARE = 8'h13;
    // Timer control bit positions
    localparam int CTL_RUN_A = 0;
    localparam int CTL_RUN_B = 1;
    localparam int CTL_IEN_LO = 2;
    localparam int CTL_IEN_HI = 3;
    localparam int CTL_CLR_A = 4;
    localparam int CTL_CLR_B = 5;
    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM = 1900;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] port;
        logic [7:0] wdata;
        logic [9:0] cycles;
    } port_item_t;

    typedef struct packed {
        logic [7:0] rd;
        logic       irq;
    } timer_result_t;

    typedef struct packed {
        port_item_t    it;
        logic          fixed;
        timer_result_t res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    fm_chip_dual_timer_irq i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Timer model state
    logic [7:0] mdl_addr;
    logic [9:0] mdl_ta;
    logic [7:0] mdl_tb;
    logic [1:0] mdl_ien;
    logic [1:0] mdl_run;
    logic [1:0] mdl_flags;
    int         mdl_cnt_a;
    int         mdl_cnt_b;
    logic [7:0] mdl_latch;
    logic       mdl_irq;

    timer_result_t pending_results[$];
    int            mismatches = 0;
    int            counted_items = 0;
    logic          calm = 1'b0;
    logic          drain_first = 1'b0;
    dir_row_t      dir_rows [0:N_DIRECTED-1];

    function automatic int period_a_clocks();
        return (1024 - int'(mdl_ta)) * 64;
    endfunction

    function automatic int period_b_clocks();
        return (256 - int'(mdl_tb)) * 1024;
    endfunction

    function automatic port_item_t mk_item(logic [1:0] c, logic [7:0] p, logic [7:0] w,
                                           logic [9:0] n);
        port_item_t it;
        it.cmd = c;
        it.port = p;
        it.wdata = w;
        it.cycles = n;
        return it;
    endfunction

    // Applies one item to the timer model and returns the result it causes.
    task automatic fm_timer_step(input port_item_t it, output timer_result_t res);
        logic [9:0] clocks;
        res = '0;
        case (it.cmd)
            CMD_WRITE: begin
                if (!it.port[PORT_LATCH_BIT]) begin
                    if (!it.port[0]) begin
                        mdl_addr = it.wdata;
                    end else begin
                        case (mdl_addr)
                            ADDR_TA_HI: mdl_ta = {it.wdata, mdl_ta[1:0]};
                            ADDR_TA_LO: mdl_ta = {mdl_ta[9:2], it.wdata[1:0]};
                            ADDR_TB:    mdl_tb = it.wdata;
                            ADDR_CTRL: begin
                                mdl_ien = it.wdata[CTL_IEN_HI:CTL_IEN_LO];
                                // A timer is loaded only on the step from stopped to running.
                                if (it.wdata[CTL_RUN_A] && !mdl_run[0])
                                    mdl_cnt_a = period_a_clocks();
                                if (it.wdata[CTL_RUN_B] && !mdl_run[1])
                                    mdl_cnt_b = period_b_clocks();
                                mdl_run = {it.wdata[CTL_RUN_B], it.wdata[CTL_RUN_A]};
                                if (it.wdata[CTL_CLR_A]) mdl_flags[0] = 1'b0;
                                if (it.wdata[CTL_CLR_B]) mdl_flags[1] = 1'b0;
                                mdl_irq = |(mdl_flags & mdl_ien);
                            end
                            default: ;
                        endcase
                    end
                end
            end
            CMD_READ: begin
                res.rd = it.port[PORT_LATCH_BIT] ? mdl_latch : {6'd0, mdl_flags};
            end
            CMD_ADV: begin
                clocks = (it.cycles > MAX_ADVANCE) ? MAX_ADVANCE : it.cycles;
                if (mdl_run[0]) begin
                    mdl_cnt_a = mdl_cnt_a - int'(clocks);
                    while (mdl_cnt_a <= 0) begin
                        mdl_flags[0] = 1'b1;
                        mdl_cnt_a = mdl_cnt_a + period_a_clocks();
                    end
                end
                if (mdl_run[1]) begin
                    mdl_cnt_b = mdl_cnt_b - int'(clocks);
                    while (mdl_cnt_b <= 0) begin
                        mdl_flags[1] = 1'b1;
                        mdl_cnt_b = mdl_cnt_b + period_b_clocks();
                    end
                end
                mdl_irq = |(mdl_flags & mdl_ien);
            end
            default: mdl_latch = it.wdata;
        endcase
        res.irq = mdl_irq;
    endtask

    task automatic note_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // Called in the time step of a clock edge; returns in the step of the edge
    // at which the item was taken.
    task automatic send_item(input port_item_t it, input logic use_fixed,
                             input timer_result_t fixed_res);
        timer_result_t res;
        if (drain_first) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (pending_results.size() != 0);
            drain_first = 1'b0;
        end else begin
            while (!calm && $urandom_range(0, 99) < 38) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, it.cycles, it.wdata, it.port};
        s_tuser  <= it.cmd;
        do @(posedge aclk); while (!s_tready);
        fm_timer_step(it, res);
        pending_results.push_back(use_fixed ? fixed_res : res);
        // Writes to the latch ports change nothing and are not counted.
        if (it.cmd != CMD_WRITE || !it.port[PORT_LATCH_BIT])
            counted_items++;
    endtask

    task automatic send_plain(input port_item_t it);
        send_item(it, 1'b0, '0);
    endtask

    // Address then data, on random port numbers that reach the chip.
    task automatic write_chip_reg(input logic [7:0] addr, input logic [7:0] data);
        send_plain(mk_item(CMD_WRITE, 8'($urandom) & 8'hBE, addr, 10'($urandom)));
        send_plain(mk_item(CMD_WRITE, (8'($urandom) & 8'hBF) | 8'h01, data,
                           10'($urandom)));
    endtask

    function automatic logic [9:0] pick_clocks();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 10'd0;
        if (r == 1) return 10'($urandom_range(513, 1023));
        return 10'($urandom_range(1, 512));
    endfunction

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 38);
    end

    always @(posedge aclk) begin
        timer_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", 16'd0, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] != want.rd)
                    note_mismatch("read_data", {8'd0, want.rd}, {8'd0, m_tdata[7:0]});
                if (m_tdata[8] != want.irq)
                    note_mismatch("irq", {15'd0, want.irq}, {15'd0, m_tdata[8]});
            end
        end
    end

    initial begin
        #20_000_000;
        $display("fm_chip_dual_timer_irq regression: fail");
        $finish;
    end

    initial begin
        logic [9:0] a_val;
        logic [7:0] b_val;
        logic [7:0] ctl;
        int         next_drain;
        int         n;
        int         burst_kind;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        mdl_addr = '0;
        mdl_ta = '0;
        mdl_tb = '0;
        mdl_ien = '0;
        mdl_run = '0;
        mdl_flags = '0;
        mdl_cnt_a = 0;
        mdl_cnt_b = 0;
        mdl_latch = '0;
        mdl_irq = 1'b0;

        dir_rows = '{
            // reset values of status and latch
            '{'{CMD_READ,  8'h00, 8'h00, 10'd0},    1'b1, '{8'h00, 1'b0}},
            '{'{CMD_READ,  8'h40, 8'h00, 10'd0},    1'b1, '{8'h00, 1'b0}},
            '{'{CMD_LATCH, 8'h00, 8'hFF, 10'd0},    1'b1, '{8'h00, 1'b0}},
            '{'{CMD_READ,  8'hFF, 8'h00, 10'd0},    1'b1, '{8'hFF, 1'b0}},
            // timer A = 1023, timer B = 255: shortest periods
            '{'{CMD_WRITE, 8'h00, ADDR_TA_HI, 10'd0}, 1'b0, '0},
            '{'{CMD_WRITE, 8'h01, 8'hFF, 10'd0},    1'b0, '0},
            '{'{CMD_WRITE, 8'h00, ADDR_TA_LO, 10'd0}, 1'b0, '0},
            '{'{CMD_WRITE, 8'hBF, 8'h03, 10'd0},    1'b0, '0},
            '{'{CMD_WRITE, 8'h00, ADDR_TB, 10'd0},  1'b0, '0},
            '{'{CMD_WRITE, 8'h01, 8'hFF, 10'd0},    1'b0, '0},
            '{'{CMD_WRITE, 8'h00, ADDR_CTRL, 10'd0}, 1'b0, '0},
            // a data write on a latch port must not start the timers
            '{'{CMD_WRITE, 8'h41, 8'h3F, 10'd0},    1'b1, '{8'h00, 1'b0}},
            '{'{CMD_ADV,   8'h00, 8'h00, 10'd1023}, 1'b1, '{8'h00, 1'b0}},
            '{'{CMD_WRITE, 8'h01, 8'h0F, 10'd0},    1'b0, '0},
            '{'{CMD_ADV,   8'h00, 8'h00, 10'd0},    1'b0, '0},
            // capped advance with eight reloads of timer A
            '{'{CMD_ADV,   8'h00, 8'h00, 10'd1023}, 1'b0, '0},
            '{'{CMD_ADV,   8'h00, 8'h00, 10'd512},  1'b0, '0},
            '{'{CMD_READ,  8'h00, 8'h00, 10'd0},    1'b1, '{8'h03, 1'b1}},
            '{'{CMD_READ,  8'h40, 8'h00, 10'd0},    1'b1, '{8'hFF, 1'b1}},
            // unused register: data is dropped, IRQ line holds
            '{'{CMD_WRITE, 8'h00, ADDR_SPARE, 10'd0}, 1'b1, '{8'h00, 1'b1}},
            '{'{CMD_WRITE, 8'h01, 8'hAA, 10'd0},    1'b1, '{8'h00, 1'b1}},
            '{'{CMD_WRITE, 8'h00, ADDR_CTRL, 10'd0}, 1'b1, '{8'h00, 1'b1}},
            // still running: no reload, flags cleared, enables off
            '{'{CMD_WRITE, 8'h01, 8'h33, 10'd0},    1'b0, '0},
            '{'{CMD_ADV,   8'h00, 8'h00, 10'd511},  1'b0, '0},
            '{'{CMD_WRITE, 8'h01, 8'h00, 10'd0},    1'b0, '0}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].res);

        counted_items = 0;
        next_drain = 0;
        while (counted_items < N_RANDOM) begin
            if (counted_items >= next_drain) begin
                drain_first = 1'b1;
                next_drain = next_drain + 400;
            end
            calm = (counted_items >= 600 && counted_items < 900);
            burst_kind = $urandom_range(0, 9);
            case (burst_kind)
                0, 1: begin
                    // program both timers, mostly with short periods, and usually start them
                    a_val = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(960, 1023))
                                                        : 10'($urandom);
                    b_val = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(248, 255))
                                                        : 8'($urandom);
                    write_chip_reg(ADDR_TA_HI, a_val[9:2]);
                    write_chip_reg(ADDR_TA_LO, {6'($urandom), a_val[1:0]});
                    write_chip_reg(ADDR_TB, b_val);
                    ctl = 8'($urandom);
                    if ($urandom_range(0, 9) < 7) ctl = ctl | 8'h03;
                    write_chip_reg(ADDR_CTRL, ctl);
                end
                2, 3, 4, 5, 6: begin
                    n = $urandom_range(3, 12);
                    repeat (n) begin
                        case ($urandom_range(0, 9))
                            0, 1: send_plain(mk_item(CMD_READ, 8'($urandom), 8'($urandom),
                                                     10'($urandom)));
                            2: begin
                                ctl = 8'($urandom);
                                if ($urandom_range(0, 3) != 0) ctl = ctl | 8'h03;
                                write_chip_reg(ADDR_CTRL, ctl);
                            end
                            default: send_plain(mk_item(CMD_ADV, 8'($urandom), 8'($urandom),
                                                        pick_clocks()));
                        endcase
                    end
                end
                7: begin
                    send_plain(mk_item(CMD_LATCH, 8'($urandom), 8'($urandom), 10'($urandom)));
                    send_plain(mk_item(CMD_READ, 8'($urandom) | 8'h40, 8'($urandom),
                                       10'($urandom)));
                end
                8: begin
                    // stop, then restart, so that the reload on start is seen again
                    write_chip_reg(ADDR_CTRL, 8'($urandom) & 8'hFC);
                    write_chip_reg(ADDR_CTRL, 8'($urandom) | 8'h03);
                end
                default: begin
                    send_plain(mk_item(2'($urandom), 8'($urandom), 8'($urandom),
                                       10'($urandom)));
                end
            endcase
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("fm_chip_dual_timer_irq regression: pass");
        end else begin
            $display("fm_chip_dual_timer_irq regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/fmt_pkg.sv
hdl/fmt_advance.sv
hdl/fm_chip_dual_timer_irq.sv
hdl/fmt_checker.sv
bench/tb.sv
